FILE: rtl/iisum_pkg.sv
// Shared constants, register codes and stage types for the integral image core.
`default_nettype none

package iisum_pkg;

    localparam int unsigned MAX_WIDTH_DEF    = 4096;
    localparam int unsigned MAX_CHANNELS_DEF = 4;
    localparam int unsigned MAX_HEIGHT_DEF   = 4096;

    localparam int unsigned DIM_W       = 13;
    localparam int unsigned CHAN_CFG_W  = 3;
    localparam int unsigned SAMPLE_W    = 8;
    localparam int unsigned SUM_W       = 32;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 13;

    localparam int unsigned OFIFO_DEPTH = 4;

    localparam logic [DIM_W-1:0]      WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0]      HEIGHT_RST = 13'd480;
    localparam logic [CHAN_CFG_W-1:0] CHAN_RST   = 3'd1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH    = 2'd0,
        REG_IMAGE_HEIGHT   = 2'd1,
        REG_CHANNEL_COUNT  = 2'd2,
        REG_SIGNED_SAMPLES = 2'd3
    } cfg_reg_t;

    // Control that travels with a request from the read stage to the add stage.
    typedef struct packed {
        logic valid;
        logic first_row;
        logic last;
        logic fwd_hit;
    } s1_flags_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             last;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/integral_image_8bit_multichannel_core.sv
// Streaming summed-area table core for interleaved 8-bit multichannel pixels.
// Results pass the stage-one register and the result queue. Throughput: one
// sample per cycle while the queue has room; the line store takes one read
// and one write each cycle, and a write-to-read bypass covers rows of one
// entry. Reset: aresetn (synchronous) clears positions, row prefixes, queue
// and registers; the line store is not cleared, since row zero never reads it.
`default_nettype none

module integral_image_8bit_multichannel_core #(
    parameter int unsigned MAX_WIDTH    = iisum_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_CHANNELS = iisum_pkg::MAX_CHANNELS_DEF,
    parameter int unsigned MAX_HEIGHT   = iisum_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [iisum_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [iisum_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [iisum_pkg::SAMPLE_W-1:0]      s_sample,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [iisum_pkg::SUM_W-1:0]       m_integral_sum,
    output logic                                     m_frame_end
);

    localparam int unsigned DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned SW    = iisum_pkg::SUM_W;
    localparam int unsigned QD    = iisum_pkg::OFIFO_DEPTH;
    localparam int unsigned NW    = $clog2(QD + 1);

    logic [iisum_pkg::DIM_W-1:0]      width_reg, height_reg;
    logic [iisum_pkg::CHAN_CFG_W-1:0] chan_reg;
    logic                             signed_reg;

    logic                 accept;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [SW-1:0]        rd_data;
    iisum_pkg::s1_flags_t s1_flags;
    logic [AW-1:0]        s1_addr;
    logic [SW-1:0]        s1_prefix;
    logic [SW-1:0]        above, sum;
    logic [SW-1:0]        fwd_data_reg;
    iisum_pkg::result_t   push_item, pop_item;
    logic [NW-1:0]        q_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= iisum_pkg::WIDTH_RST;
            height_reg <= iisum_pkg::HEIGHT_RST;
            chan_reg   <= iisum_pkg::CHAN_RST;
            signed_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (iisum_pkg::cfg_reg_t'(cfg_index))
                iisum_pkg::REG_IMAGE_WIDTH:    width_reg  <= cfg_wr_data;
                iisum_pkg::REG_IMAGE_HEIGHT:   height_reg <= cfg_wr_data;
                iisum_pkg::REG_CHANNEL_COUNT:  chan_reg   <= cfg_wr_data[2:0];
                iisum_pkg::REG_SIGNED_SAMPLES: signed_reg <= cfg_wr_data[0];
            endcase
        end
    end

    // Admit a request only if every request in flight still finds a queue slot.
    assign s_ready = (NW'(q_count) + NW'(s1_flags.valid)) < NW'(QD);
    assign accept  = s_valid && s_ready;

    iisum_ctrl #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_HEIGHT   (MAX_HEIGHT)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .image_width    (width_reg),
        .image_height   (height_reg),
        .channel_count  (chan_reg),
        .signed_samples (signed_reg),
        .accept         (accept),
        .sample         (s_sample),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .s1_flags       (s1_flags),
        .s1_addr        (s1_addr),
        .s1_prefix      (s1_prefix)
    );

    iisum_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (s1_flags.valid),
        .wr_addr (s1_addr),
        .wr_data (sum),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        if (s1_flags.first_row) begin
            above = '0;
        end else if (s1_flags.fwd_hit) begin
            above = fwd_data_reg;
        end else begin
            above = rd_data;
        end
    end

    assign sum = above + s1_prefix;

    // Hold the last written word for a back-to-back access of the same entry.
    always_ff @(posedge aclk) begin
        fwd_data_reg <= sum;
    end

    assign push_item.sum  = sum;
    assign push_item.last = s1_flags.last;

    iisum_ofifo u_ofifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s1_flags.valid),
        .push_item (push_item),
        .pop_ready (m_ready),
        .pop_valid (m_valid),
        .pop_item  (pop_item),
        .count     (q_count)
    );

    assign m_integral_sum = pop_item.sum;
    assign m_frame_end    = pop_item.last;

    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_flags.valid |-> (q_count < NW'(QD)))
        else $error("result queue overflow");

    a_fwd_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_flags.fwd_hit |-> (s1_flags.valid && $past(s1_flags.valid)))
        else $error("bypass without a preceding write");

    a_read_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |=> (s1_flags.valid && !s1_flags.first_row))
        else $error("line store read without a matching request");

endmodule

`default_nettype wire

FILE: rtl/iisum_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module iisum_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16384,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic [WIDTH-1:0]   rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read-first: a read of the address being written returns the old word.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/iisum_ctrl.sv
// Position counters, row prefix sums and line store addressing.
`default_nettype none

module iisum_ctrl #(
    parameter int unsigned MAX_WIDTH    = iisum_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_CHANNELS = iisum_pkg::MAX_CHANNELS_DEF,
    parameter int unsigned MAX_HEIGHT   = iisum_pkg::MAX_HEIGHT_DEF,
    localparam int unsigned AW = (MAX_WIDTH * MAX_CHANNELS > 1) ?
                                 $clog2(MAX_WIDTH * MAX_CHANNELS) : 1
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic [iisum_pkg::DIM_W-1:0]        image_width,
    input  wire logic [iisum_pkg::DIM_W-1:0]        image_height,
    input  wire logic [iisum_pkg::CHAN_CFG_W-1:0]   channel_count,
    input  wire logic                               signed_samples,
    input  wire logic                               accept,
    input  wire logic [iisum_pkg::SAMPLE_W-1:0]     sample,
    output logic                                    rd_en,
    output logic [AW-1:0]                           rd_addr,
    output iisum_pkg::s1_flags_t                    s1_flags,
    output logic [AW-1:0]                           s1_addr,
    output logic [iisum_pkg::SUM_W-1:0]             s1_prefix
);

    localparam int unsigned CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int unsigned HW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int unsigned WDW = ($clog2(MAX_WIDTH + 1) > iisum_pkg::DIM_W) ?
                                  $clog2(MAX_WIDTH + 1) : iisum_pkg::DIM_W;
    localparam int unsigned HDW = ($clog2(MAX_HEIGHT + 1) > iisum_pkg::DIM_W) ?
                                  $clog2(MAX_HEIGHT + 1) : iisum_pkg::DIM_W;
    localparam int unsigned CCW = iisum_pkg::CHAN_CFG_W;
    localparam int unsigned SW  = iisum_pkg::SUM_W;

    logic [CW-1:0] col_reg, col_next, col_eff;
    logic [RW-1:0] row_reg, row_next, row_eff;
    logic [HW-1:0] ch_reg, ch_next, ch_eff;
    logic [SW-1:0] prefix_reg [MAX_CHANNELS];

    logic [WDW-1:0] w_eff;
    logic [HDW-1:0] h_eff;
    logic [CCW-1:0] c_eff;
    logic           ch_wrap, col_wrap, row_wrap;
    logic [SW-1:0]  s_ext, prefix_cur;
    logic [AW-1:0]  addr;

    iisum_pkg::s1_flags_t s1_flags_reg, s1_flags_next;
    logic [AW-1:0]        s1_addr_reg;
    logic [SW-1:0]        s1_prefix_reg;

    // Saturate the geometry into its legal range.
    always_comb begin
        if (image_width == '0) begin
            w_eff = WDW'(1);
        end else if (WDW'(image_width) > WDW'(MAX_WIDTH)) begin
            w_eff = WDW'(MAX_WIDTH);
        end else begin
            w_eff = WDW'(image_width);
        end
        if (image_height == '0) begin
            h_eff = HDW'(1);
        end else if (HDW'(image_height) > HDW'(MAX_HEIGHT)) begin
            h_eff = HDW'(MAX_HEIGHT);
        end else begin
            h_eff = HDW'(image_height);
        end
        if (channel_count == '0) begin
            c_eff = CCW'(1);
        end else if (channel_count > CCW'(MAX_CHANNELS)) begin
            c_eff = CCW'(MAX_CHANNELS);
        end else begin
            c_eff = channel_count;
        end
    end

    // Pull positions that lie beyond a shrunk geometry back to the last slot.
    assign col_eff = (WDW'(col_reg) >= w_eff) ? CW'(w_eff - WDW'(1)) : col_reg;
    assign row_eff = (HDW'(row_reg) >= h_eff) ? RW'(h_eff - HDW'(1)) : row_reg;
    assign ch_eff  = (CCW'(ch_reg) >= c_eff) ? HW'(c_eff - CCW'(1)) : ch_reg;

    assign ch_wrap  = (CCW'(ch_eff) + CCW'(1)) >= c_eff;
    assign col_wrap = ch_wrap && ((WDW'(col_eff) + WDW'(1)) >= w_eff);
    assign row_wrap = col_wrap && ((HDW'(row_eff) + HDW'(1)) >= h_eff);

    assign ch_next  = ch_wrap ? '0 : ch_eff + HW'(1);
    assign col_next = col_wrap ? '0 : (ch_wrap ? col_eff + CW'(1) : col_eff);
    assign row_next = row_wrap ? '0 : (col_wrap ? row_eff + RW'(1) : row_eff);

    assign s_ext = signed_samples ? {{(SW - iisum_pkg::SAMPLE_W){sample[7]}}, sample}
                                  : {{(SW - iisum_pkg::SAMPLE_W){1'b0}}, sample};

    assign prefix_cur = (col_eff == '0) ? s_ext : prefix_reg[ch_eff] + s_ext;

    assign addr = AW'(AW'(col_eff) * AW'(c_eff)) + AW'(ch_eff);

    always_comb begin
        s1_flags_next.valid     = accept;
        s1_flags_next.first_row = (row_eff == '0);
        s1_flags_next.last      = row_wrap;
        // The previous request writes this entry in the same cycle.
        s1_flags_next.fwd_hit   = accept && s1_flags_reg.valid && (s1_addr_reg == addr);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            ch_reg       <= '0;
            s1_flags_reg <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                prefix_reg[i] <= '0;
            end
        end else begin
            s1_flags_reg <= s1_flags_next;
            if (accept) begin
                col_reg            <= col_next;
                row_reg            <= row_next;
                ch_reg             <= ch_next;
                prefix_reg[ch_eff] <= prefix_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_addr_reg   <= addr;
            s1_prefix_reg <= prefix_cur;
        end
    end

    assign rd_en     = accept && (row_eff != '0);
    assign rd_addr   = addr;
    assign s1_flags  = s1_flags_reg;
    assign s1_addr   = s1_addr_reg;
    assign s1_prefix = s1_prefix_reg;

endmodule

`default_nettype wire

FILE: rtl/iisum_ofifo.sv
// Small result queue that decouples the add stage from the result channel.
`default_nettype none

module iisum_ofifo #(
    localparam int unsigned DEPTH = iisum_pkg::OFIFO_DEPTH,
    localparam int unsigned PW    = $clog2(DEPTH),
    localparam int unsigned NW    = $clog2(DEPTH + 1)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire iisum_pkg::result_t push_item,
    input  wire logic               pop_ready,
    output logic                    pop_valid,
    output iisum_pkg::result_t      pop_item,
    output logic [NW-1:0]           count
);

    iisum_pkg::result_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          pop;

    assign pop         = pop_valid && pop_ready;
    assign wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
    assign rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
    assign count_next  = count_reg + NW'(push) - NW'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_valid = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

`default_nettype wire
